### rtl/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants of the fraction arithmetic core
// Holds the operation codes, the sequencer states and the request and
// response records of the shared subtract unit.
// ----------------------------------------------------------------------------
package fra_pkg;

   localparam int IN_W  = 16;   // width of one input numerator or denominator
   localparam int PROD_W = 32;  // width of one signed 16 x 16 product
   localparam int NUM_W = 33;   // width of the result numerator
   localparam int DEN_W = 32;   // width of the result denominator
   localparam int MAG_W = 32;   // width of a magnitude in the reduction
   localparam int ALU_W = 33;   // width of the shared subtract unit
   localparam int CNT_W = 5;    // bit counter of the divider

   // Operation codes.
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   // Product steps of the multiply phase.
   localparam logic [1:0] MSTEP_P0  = 2'd0;
   localparam logic [1:0] MSTEP_P1  = 2'd1;
   localparam logic [1:0] MSTEP_DEN = 2'd2;
   localparam logic [1:0] MSTEP_END = 2'd3;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_MUL  = 11'b000_0000_0010,
      ST_ABSN = 11'b000_0000_0100,
      ST_ABSD = 11'b000_0000_1000,
      ST_TWO  = 11'b000_0001_0000,
      ST_GCD  = 11'b000_0010_0000,
      ST_DIVN = 11'b000_0100_0000,
      ST_NEGN = 11'b000_1000_0000,
      ST_DIVD = 11'b001_0000_0000,
      ST_NEGD = 11'b010_0000_0000,
      ST_DONE = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [ALU_W-1:0] opa;
      logic [ALU_W-1:0] opb;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             borrow;
      logic             zero;
   } alu_rsp_type;

endpackage

### rtl/fra_mul.sv
// ----------------------------------------------------------------------------
// fra_mul: registered signed 16 x 16 multiplier
// Forms one product per cycle; the product is registered and appears in
// the cycle after its operands.
// ----------------------------------------------------------------------------
module fra_mul (
   input  logic                                clock,
   input  logic signed [fra_pkg::IN_W-1:0]     op_a,
   input  logic signed [fra_pkg::IN_W-1:0]     op_b,
   output logic signed [fra_pkg::PROD_W-1:0]   prod
);
   import fra_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a * op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/fra_alu.sv
// ----------------------------------------------------------------------------
// fra_alu: shared subtract and compare unit
// Computes opa - opb with a borrow out and a zero flag. It serves the
// magnitude, GCD, division and sign steps in turn.
// ----------------------------------------------------------------------------
module fra_alu (
   input  fra_pkg::alu_req_type req,
   output fra_pkg::alu_rsp_type rsp
);
   import fra_pkg::*;

   logic [ALU_W:0] wide_diff;

   assign wide_diff  = {1'b0, req.opa} - {1'b0, req.opb};
   assign rsp.diff   = wide_diff[ALU_W-1:0];
   assign rsp.borrow = wide_diff[ALU_W];
   assign rsp.zero   = (wide_diff[ALU_W-1:0] == '0);

endmodule

### rtl/fraction_arith_reduce_core.sv
// ----------------------------------------------------------------------------
// fraction_arith_reduce_core: signed fraction arithmetic with GCD reduction
// Adds, subtracts, multiplies or divides two 16-bit fractions and returns
// the result reduced by the greatest common divisor of its magnitudes.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the req_ channel (valid/ready) carrying an operation
// code and two fractions num_a/den_a and num_b/den_b. The block takes one
// item at a time: req_ready is high only while the sequencer is idle.
// Each item gives exactly one result item on the rsp_ channel: the reduced
// numerator and denominator, with the signs as the products leave them, and
// a div_zero flag when the raw denominator is zero (both fields then zero).
// A zero numerator over a nonzero denominator gives 0/1.
// Steps: the products through one shared multiplier, the two magnitudes,
// the stripping of the common factors of two, the binary GCD steps, then
// two restoring divisions with a sign step each and a load of the output
// register, one shared subtractor doing all of it.
// A new item is taken in the same cycle as rsp_valid rises at the earliest.
// The result waits in an output register, so the next item is taken while
// a finished one is still held by a stalled receiver; a second finished
// result waits in the sequencer until the first one is taken.
// Reset clears the sequencer and drops rsp_valid; an item in flight is lost.
// ----------------------------------------------------------------------------
module fraction_arith_reduce_core (
   input  logic                               clock,
   input  logic                               reset,
   // Input channel.
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic signed [fra_pkg::IN_W-1:0]    req_num_a,
   input  logic signed [fra_pkg::IN_W-1:0]    req_den_a,
   input  logic signed [fra_pkg::IN_W-1:0]    req_num_b,
   input  logic signed [fra_pkg::IN_W-1:0]    req_den_b,
   // Result channel.
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [fra_pkg::NUM_W-1:0]   rsp_res_num,
   output logic signed [fra_pkg::DEN_W-1:0]   rsp_res_den,
   output logic                               rsp_div_zero
);
   import fra_pkg::*;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

   // Sequencer and captured item.
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0] mode_ff, mode_in;
   logic signed [IN_W-1:0] na_ff, na_in, da_ff, da_in, nb_ff, nb_in, db_ff, db_in;

   // Raw fraction and reduction registers.
   logic signed [NUM_W-1:0] n_ff, n_in;
   logic signed [DEN_W-1:0] d_ff, d_in;
   logic [MAG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [MAG_W-1:0] mn_ff, mn_in, md_ff, md_in;
   logic [MAG_W-1:0] rem_ff, rem_in, q_ff, q_in;

   // Staged result, and the output register.
   logic [NUM_W-1:0] qn_ff, qn_in;
   logic [DEN_W-1:0] qd_ff, qd_in;
   logic             dz_ff, dz_in;
   logic [NUM_W-1:0] res_num_ff, res_num_in;
   logic [DEN_W-1:0] res_den_ff, res_den_in;
   logic             res_dz_ff, res_dz_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Shared units.
   logic signed [IN_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   alu_req_type              alu_req;
   alu_rsp_type              alu_rsp;

   logic             req_fire;
   logic             out_free;
   logic [ALU_W-1:0] rem_shift;

   fra_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   fra_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_shift = {rem_ff, q_ff[MAG_W-1]};

   // Multiplier operands follow the product step of the multiply phase.
   always_comb begin
      mul_a = na_ff;
      mul_b = (mode_ff == MODE_MUL) ? nb_ff : db_ff;
      case (cnt_ff[1:0])
         MSTEP_P1: begin
            mul_a = nb_ff;
            mul_b = da_ff;
         end
         MSTEP_DEN: begin
            mul_a = da_ff;
            mul_b = (mode_ff == MODE_DIV) ? nb_ff : db_ff;
         end
         default: begin
         end
      endcase
   end

   // The shared subtractor is steered by the state.
   always_comb begin
      alu_req.opa = {1'b0, x_ff};
      alu_req.opb = {1'b0, y_ff};
      case (state_ff)
         ST_ABSN: begin
            alu_req.opa = '0;
            alu_req.opb = n_ff;
         end
         ST_ABSD: begin
            alu_req.opa = '0;
            alu_req.opb = {d_ff[DEN_W-1], d_ff};
         end
         ST_DIVN, ST_DIVD: begin
            alu_req.opa = rem_shift;
            alu_req.opb = {1'b0, x_ff};
         end
         ST_NEGN, ST_NEGD: begin
            alu_req.opa = '0;
            alu_req.opb = {1'b0, q_ff};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      na_in        = na_ff;
      da_in        = da_ff;
      nb_in        = nb_ff;
      db_in        = db_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mn_in        = mn_ff;
      md_in        = md_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      dz_in        = dz_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      res_dz_in    = res_dz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               na_in    = req_num_a;
               da_in    = req_den_a;
               nb_in    = req_num_b;
               db_in    = req_den_b;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The product of the previous step is ready in this cycle.
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff[1:0])
               MSTEP_P1: begin
                  n_in = {prod[PROD_W-1], prod};
               end
               MSTEP_DEN: begin
                  if (mode_ff == MODE_ADD) begin
                     n_in = n_ff + {prod[PROD_W-1], prod};
                  end else if (mode_ff == MODE_SUB) begin
                     n_in = n_ff - {prod[PROD_W-1], prod};
                  end
               end
               MSTEP_END: begin
                  d_in     = prod;
                  state_in = ST_ABSN;
               end
               default: begin
               end
            endcase
         end
         ST_ABSN: begin
            if (d_ff == '0) begin
               qn_in    = '0;
               qd_in    = '0;
               dz_in    = 1'b1;
               state_in = ST_DONE;
            end else if (n_ff == '0) begin
               qn_in    = '0;
               qd_in    = DEN_W'(1);
               dz_in    = 1'b0;
               state_in = ST_DONE;
            end else begin
               x_in     = n_ff[NUM_W-1] ? alu_rsp.diff[MAG_W-1:0] : n_ff[MAG_W-1:0];
               state_in = ST_ABSD;
            end
         end
         ST_ABSD: begin
            y_in     = d_ff[DEN_W-1] ? alu_rsp.diff[MAG_W-1:0] : d_ff;
            state_in = ST_TWO;
         end
         ST_TWO: begin
            // Strip the common factors of two; the stripped magnitudes are
            // the dividends of the two divisions by the odd part of the GCD.
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
            end else begin
               mn_in    = x_ff;
               md_in    = y_ff;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (alu_rsp.zero) begin
               // x now holds the odd part of the GCD.
               q_in     = mn_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVN;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (alu_rsp.borrow) begin
               // Keep the larger value in x before subtracting.
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               // The difference of two odd values is even: halve it at once.
               x_in = alu_rsp.diff[MAG_W:1];
            end
         end
         ST_DIVN, ST_DIVD: begin
            if (!alu_rsp.borrow) begin
               rem_in = alu_rsp.diff[MAG_W-1:0];
            end else begin
               rem_in = rem_shift[MAG_W-1:0];
            end
            q_in   = {q_ff[MAG_W-2:0], !alu_rsp.borrow};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = (state_ff == ST_DIVN) ? ST_NEGN : ST_NEGD;
            end
         end
         ST_NEGN: begin
            qn_in    = n_ff[NUM_W-1] ? alu_rsp.diff : {1'b0, q_ff};
            q_in     = md_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIVD;
         end
         ST_NEGD: begin
            qd_in    = d_ff[DEN_W-1] ? alu_rsp.diff[DEN_W-1:0] : q_ff;
            dz_in    = 1'b0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               res_num_in   = qn_ff;
               res_den_in   = qd_ff;
               res_dz_in    = dz_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      na_ff      <= na_in;
      da_ff      <= da_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      mn_ff      <= mn_in;
      md_ff      <= md_in;
      rem_ff     <= rem_in;
      q_ff       <= q_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      dz_ff      <= dz_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      res_dz_ff  <= res_dz_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = res_num_ff;
   assign rsp_res_den  = res_den_ff;
   assign rsp_div_zero = res_dz_ff;

`ifndef SYNTH
   // A zero denominator always reports a zero fraction.
   a_dz_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("div_zero result carries nonzero fields");

   // A valid result without div_zero never has a zero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_div_zero) |-> (rsp_res_den != '0))
      else $error("reduced denominator is zero");

   // The binary GCD only ever works on nonzero magnitudes.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD || state_ff == ST_TWO) |-> (x_ff != '0 && y_ff != '0))
      else $error("GCD operand reached zero");

   // An accepted item keeps the block busy for at least the product phase.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("new item taken while busy");
`endif

endmodule
